FILE: rtl/lspf_pkg.sv
// lspf_pkg: types, widths, register-file map and solve microprogram for the
// least-squares parabola fit. No dependencies; used by every rtl file.
`timescale 1ns / 1ps
package lspf_pkg;

   localparam int XW      = 12;
   localparam int YW      = 16;
   localparam int COEF_W  = 64;
   localparam int FRAC    = 24;
   // every intermediate of the exact solve fits in this signed width
   localparam int W       = 160;
   localparam int QW      = W + FRAC;
   localparam int SX_W    = 24;
   localparam int SX2_W   = 34;
   localparam int SX3_W   = 45;
   localparam int SX4_W   = 56;
   localparam int SY_W    = 27;
   localparam int SXY_W   = 38;
   localparam int SX2Y_W  = 49;
   localparam int RA_W    = 5;

   // register file map
   localparam logic [RA_W-1:0] R_N    = 5'd0;
   localparam logic [RA_W-1:0] R_SX   = 5'd1;
   localparam logic [RA_W-1:0] R_SX2  = 5'd2;
   localparam logic [RA_W-1:0] R_SX3  = 5'd3;
   localparam logic [RA_W-1:0] R_SX4  = 5'd4;
   localparam logic [RA_W-1:0] R_SY   = 5'd5;
   localparam logic [RA_W-1:0] R_SXY  = 5'd6;
   localparam logic [RA_W-1:0] R_SX2Y = 5'd7;
   localparam logic [RA_W-1:0] R_ONE  = 5'd8;
   localparam logic [RA_W-1:0] R_DET  = 5'd9;
   localparam logic [RA_W-1:0] R_P3   = 5'd10;
   localparam logic [RA_W-1:0] R_P4   = 5'd11;
   localparam logic [RA_W-1:0] R_P5   = 5'd12;
   localparam logic [RA_W-1:0] R_A00  = 5'd13;
   localparam logic [RA_W-1:0] R_A11  = 5'd14;
   localparam logic [RA_W-1:0] R_A22  = 5'd15;
   localparam logic [RA_W-1:0] R_T    = 5'd16;
   localparam logic [RA_W-1:0] R_C0   = 5'd17;
   localparam logic [RA_W-1:0] R_C1   = 5'd18;
   localparam logic [RA_W-1:0] R_C2   = 5'd19;
   // coefficient slots for divide results
   localparam logic [RA_W-1:0] K_CONST  = 5'd0;
   localparam logic [RA_W-1:0] K_LINEAR = 5'd1;
   localparam logic [RA_W-1:0] K_SQUARE = 5'd2;

   typedef enum logic [2:0] {
      OP_LOAD, OP_STORE, OP_SET, OP_MADD, OP_MSUB, OP_DIV, OP_CHECK, OP_END
   } op_type;

   typedef enum logic [1:0] {
      FIT_OK, FIT_TOO_FEW, FIT_SINGULAR, FIT_OVERFLOW
   } fit_status_type;

   typedef struct packed {
      op_type          op;
      logic [RA_W-1:0] ra;
      logic [RA_W-1:0] rb;
      logic [RA_W-1:0] rd;
   } ucode_type;

   typedef struct packed {
      logic            start;
      op_type          op;
      logic [RA_W-1:0] ra;
      logic [RA_W-1:0] rb;
      logic [RA_W-1:0] rd;
      logic            clear_sums;
      logic            clear_coef;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic pipe_empty;
      logic too_few;
      logic overflow;
      logic acc_zero;
   } stat_type;

   localparam int UCODE_LEN = 69;
   localparam int PC_W      = 7;

   // acc ops: SET acc=a*b, MADD acc+=a*b, MSUB acc-=a*b; b is the multiplier
   localparam ucode_type UCODE [UCODE_LEN] = '{
      '{OP_LOAD,  R_N,   R_N,    R_N},
      '{OP_LOAD,  R_N,   R_N,    R_SX},
      '{OP_LOAD,  R_N,   R_N,    R_SX2},
      '{OP_LOAD,  R_N,   R_N,    R_SX3},
      '{OP_LOAD,  R_N,   R_N,    R_SX4},
      '{OP_LOAD,  R_N,   R_N,    R_SY},
      '{OP_LOAD,  R_N,   R_N,    R_SXY},
      '{OP_LOAD,  R_N,   R_N,    R_SX2Y},
      '{OP_LOAD,  R_N,   R_N,    R_ONE},
      // determinant
      '{OP_SET,   R_SX2, R_N,    R_N},
      '{OP_STORE, R_N,   R_N,    R_T},
      '{OP_SET,   R_SX4, R_T,    R_N},
      '{OP_STORE, R_N,   R_N,    R_DET},
      '{OP_SET,   R_SX2, R_SX,   R_N},
      '{OP_STORE, R_N,   R_N,    R_T},
      '{OP_SET,   R_SX3, R_T,    R_N},
      '{OP_MADD,  R_SX3, R_T,    R_N},
      '{OP_MADD,  R_DET, R_ONE,  R_N},
      '{OP_STORE, R_N,   R_N,    R_DET},
      '{OP_SET,   R_SX3, R_N,    R_N},
      '{OP_STORE, R_N,   R_N,    R_T},
      '{OP_SET,   R_DET, R_ONE,  R_N},
      '{OP_MSUB,  R_SX3, R_T,    R_N},
      '{OP_STORE, R_N,   R_N,    R_DET},
      '{OP_SET,   R_SX,  R_SX,   R_N},
      '{OP_STORE, R_N,   R_N,    R_T},
      '{OP_SET,   R_DET, R_ONE,  R_N},
      '{OP_MSUB,  R_SX4, R_T,    R_N},
      '{OP_STORE, R_N,   R_N,    R_DET},
      '{OP_SET,   R_SX2, R_SX2,  R_N},
      '{OP_STORE, R_N,   R_N,    R_T},
      '{OP_SET,   R_DET, R_ONE,  R_N},
      '{OP_MSUB,  R_SX2, R_T,    R_N},
      '{OP_STORE, R_N,   R_N,    R_DET},
      '{OP_CHECK, R_N,   R_N,    R_N},
      // cofactors
      '{OP_SET,   R_SX2, R_SX,   R_N},
      '{OP_MSUB,  R_SX3, R_N,    R_N},
      '{OP_STORE, R_N,   R_N,    R_P3},
      '{OP_SET,   R_SX3, R_SX,   R_N},
      '{OP_MSUB,  R_SX2, R_SX2,  R_N},
      '{OP_STORE, R_N,   R_N,    R_P4},
      '{OP_SET,   R_SX3, R_SX2,  R_N},
      '{OP_MSUB,  R_SX4, R_SX,   R_N},
      '{OP_STORE, R_N,   R_N,    R_P5},
      '{OP_SET,   R_SX4, R_SX2,  R_N},
      '{OP_MSUB,  R_SX3, R_SX3,  R_N},
      '{OP_STORE, R_N,   R_N,    R_A00},
      '{OP_SET,   R_SX4, R_N,    R_N},
      '{OP_MSUB,  R_SX2, R_SX2,  R_N},
      '{OP_STORE, R_N,   R_N,    R_A11},
      '{OP_SET,   R_SX2, R_N,    R_N},
      '{OP_MSUB,  R_SX,  R_SX,   R_N},
      '{OP_STORE, R_N,   R_N,    R_A22},
      // numerators
      '{OP_SET,   R_A00, R_SY,   R_N},
      '{OP_MADD,  R_P5,  R_SXY,  R_N},
      '{OP_MADD,  R_P4,  R_SX2Y, R_N},
      '{OP_STORE, R_N,   R_N,    R_C0},
      '{OP_SET,   R_P5,  R_SY,   R_N},
      '{OP_MADD,  R_A11, R_SXY,  R_N},
      '{OP_MADD,  R_P3,  R_SX2Y, R_N},
      '{OP_STORE, R_N,   R_N,    R_C1},
      '{OP_SET,   R_P4,  R_SY,   R_N},
      '{OP_MADD,  R_P3,  R_SXY,  R_N},
      '{OP_MADD,  R_A22, R_SX2Y, R_N},
      '{OP_STORE, R_N,   R_N,    R_C2},
      '{OP_DIV,   R_C0,  R_DET,  K_CONST},
      '{OP_DIV,   R_C1,  R_DET,  K_LINEAR},
      '{OP_DIV,   R_C2,  R_DET,  K_SQUARE},
      '{OP_END,   R_N,   R_N,    R_N}
   };

endpackage

FILE: rtl/lspf_dp.sv
// lspf_dp: datapath of the parabola fit - point accumulators, register file,
// bit-serial multiply-accumulate and restoring divider. Depends on lspf_pkg.
`timescale 1ns / 1ps
module lspf_dp #(
   parameter int MaxPoints = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pt_valid,
   input  logic signed [lspf_pkg::XW-1:0] pt_x,
   input  logic signed [lspf_pkg::YW-1:0] pt_y,
   input  lspf_pkg::cmd_type           cmd,
   output lspf_pkg::stat_type          stat,
   output logic [lspf_pkg::COEF_W-1:0] coef_const,
   output logic [lspf_pkg::COEF_W-1:0] coef_linear,
   output logic [lspf_pkg::COEF_W-1:0] coef_square
);
   localparam int CntW  = $clog2(MaxPoints + 1);
   localparam int W     = lspf_pkg::W;
   localparam int QW    = lspf_pkg::QW;
   localparam int DCW   = $clog2(QW);

   typedef enum logic [2:0] {
      PH_IDLE, PH_MUL_INIT, PH_MUL, PH_DIV_INIT, PH_DIV, PH_DIV_DONE
   } phase_type;

   // accumulation pipeline
   logic [CntW-1:0] cnt_ff;
   logic            ovf_ff;
   logic            v1_ff, v2_ff;
   logic signed [lspf_pkg::XW-1:0] x1_ff, x2_ff;
   logic signed [lspf_pkg::YW-1:0] y1_ff, y2_ff;
   logic signed [23:0] xx1_ff;
   logic signed [27:0] xy1_ff, xy2_ff;
   logic signed [35:0] x3_ff;
   logic signed [47:0] x4_ff;
   logic signed [39:0] xxy_ff;
   logic signed [23:0] xx2_ff;
   logic signed [lspf_pkg::SX_W-1:0]   sum_x_ff;
   logic signed [lspf_pkg::SX2_W-1:0]  sum_x_sq_ff;
   logic signed [lspf_pkg::SX3_W-1:0]  sum_x_cube_ff;
   logic signed [lspf_pkg::SX4_W-1:0]  sum_x_fourth_ff;
   logic signed [lspf_pkg::SY_W-1:0]   sum_y_ff;
   logic signed [lspf_pkg::SXY_W-1:0]  sum_xy_ff;
   logic signed [lspf_pkg::SX2Y_W-1:0] sum_x_sq_y_ff;
   logic            take;

   assign take = pt_valid && (cnt_ff < CntW'(MaxPoints));

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_sums) begin
         cnt_ff          <= '0;
         ovf_ff          <= 1'b0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         sum_x_ff        <= '0;
         sum_x_sq_ff     <= '0;
         sum_x_cube_ff   <= '0;
         sum_x_fourth_ff <= '0;
         sum_y_ff        <= '0;
         sum_xy_ff       <= '0;
         sum_x_sq_y_ff   <= '0;
      end else begin
         v1_ff <= take;
         v2_ff <= v1_ff;
         if (take) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (pt_valid && !take) begin
            ovf_ff <= 1'b1;
         end
         if (v2_ff) begin
            sum_x_ff        <= sum_x_ff + lspf_pkg::SX_W'(x2_ff);
            sum_x_sq_ff     <= sum_x_sq_ff + lspf_pkg::SX2_W'(xx2_ff);
            sum_x_cube_ff   <= sum_x_cube_ff + lspf_pkg::SX3_W'(x3_ff);
            sum_x_fourth_ff <= sum_x_fourth_ff + lspf_pkg::SX4_W'(x4_ff);
            sum_y_ff        <= sum_y_ff + lspf_pkg::SY_W'(y2_ff);
            sum_xy_ff       <= sum_xy_ff + lspf_pkg::SXY_W'(xy2_ff);
            sum_x_sq_y_ff   <= sum_x_sq_y_ff + lspf_pkg::SX2Y_W'(xxy_ff);
         end
      end
   end

   // products, one multiply level per stage
   always_ff @(posedge clock) begin
      x1_ff  <= pt_x;
      y1_ff  <= pt_y;
      xx1_ff <= pt_x * pt_x;
      xy1_ff <= pt_x * pt_y;
      x2_ff  <= x1_ff;
      y2_ff  <= y1_ff;
      xx2_ff <= xx1_ff;
      xy2_ff <= xy1_ff;
      x3_ff  <= xx1_ff * x1_ff;
      x4_ff  <= xx1_ff * xx1_ff;
      xxy_ff <= xx1_ff * y1_ff;
   end

   // register file
   logic [W-1:0] mem [32];
   logic [W-1:0] rda_ff, rdb_ff;
   logic         wr_en;
   logic [W-1:0] wr_data;
   logic [W-1:0] load_val;
   logic [W-1:0] acc_ff;

   always_comb begin
      case (cmd.rd)
         lspf_pkg::R_N:    load_val = W'(cnt_ff);
         lspf_pkg::R_SX:   load_val = W'(sum_x_ff);
         lspf_pkg::R_SX2:  load_val = W'(sum_x_sq_ff);
         lspf_pkg::R_SX3:  load_val = W'(sum_x_cube_ff);
         lspf_pkg::R_SX4:  load_val = W'(sum_x_fourth_ff);
         lspf_pkg::R_SY:   load_val = W'(sum_y_ff);
         lspf_pkg::R_SXY:  load_val = W'(sum_xy_ff);
         lspf_pkg::R_SX2Y: load_val = W'(sum_x_sq_y_ff);
         lspf_pkg::R_ONE:  load_val = W'(1);
         default:          load_val = '0;
      endcase
   end

   assign wr_en   = cmd.start && (cmd.op == lspf_pkg::OP_LOAD ||
                                  cmd.op == lspf_pkg::OP_STORE);
   assign wr_data = (cmd.op == lspf_pkg::OP_LOAD) ? load_val : acc_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cmd.rd] <= wr_data;
      end
      if (cmd.start) begin
         rda_ff <= mem[cmd.ra];
         rdb_ff <= mem[cmd.rb];
      end
   end

   // arithmetic sequencer
   phase_type       ph_ff;
   lspf_pkg::op_type op_ff;
   logic [1:0]      slot_ff;
   logic            neg_ff;
   logic [W-1:0]    mcand_ff, mplier_ff, prod_ff;
   logic [QW-1:0]   quo_ff;
   logic [W-1:0]    den_ff, rem_ff;
   logic [DCW-1:0]  dcnt_ff;
   logic [lspf_pkg::COEF_W-1:0] coef_ff [3];

   logic [W-1:0]    abs_a, abs_b, sprod;
   logic [W:0]      rem_sh;
   logic            ge;
   logic            sat;
   logic [lspf_pkg::COEF_W-1:0] qmag, qres;

   assign abs_a  = rda_ff[W-1] ? (~rda_ff + 1'b1) : rda_ff;
   assign abs_b  = rdb_ff[W-1] ? (~rdb_ff + 1'b1) : rdb_ff;
   assign sprod  = neg_ff ? (~prod_ff + 1'b1) : prod_ff;
   assign rem_sh = {rem_ff, quo_ff[QW-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};
   assign sat    = |quo_ff[QW-1:lspf_pkg::COEF_W-1];
   assign qmag   = quo_ff[lspf_pkg::COEF_W-1:0];

   always_comb begin
      if (sat) begin
         qres = neg_ff ? {1'b1, {(lspf_pkg::COEF_W-1){1'b0}}}
                       : {1'b0, {(lspf_pkg::COEF_W-1){1'b1}}};
      end else begin
         qres = neg_ff ? (~qmag + 1'b1) : qmag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE;
      end else begin
         if (cmd.clear_coef) begin
            coef_ff[0] <= '0;
            coef_ff[1] <= '0;
            coef_ff[2] <= '0;
         end
         case (ph_ff)
            PH_IDLE: begin
               if (cmd.start) begin
                  op_ff   <= cmd.op;
                  slot_ff <= cmd.rd[1:0];
                  if (cmd.op == lspf_pkg::OP_DIV) begin
                     ph_ff <= PH_DIV_INIT;
                  end else if (cmd.op == lspf_pkg::OP_SET || cmd.op == lspf_pkg::OP_MADD ||
                               cmd.op == lspf_pkg::OP_MSUB) begin
                     ph_ff <= PH_MUL_INIT;
                  end
               end
            end
            PH_MUL_INIT: begin
               mcand_ff  <= abs_a;
               mplier_ff <= abs_b;
               neg_ff    <= rda_ff[W-1] ^ rdb_ff[W-1];
               prod_ff   <= '0;
               ph_ff     <= PH_MUL;
            end
            PH_MUL: begin
               if (mplier_ff != '0) begin
                  if (mplier_ff[0]) begin
                     prod_ff <= prod_ff + mcand_ff;
                  end
                  mcand_ff  <= mcand_ff << 1;
                  mplier_ff <= mplier_ff >> 1;
               end else begin
                  case (op_ff)
                     lspf_pkg::OP_SET:  acc_ff <= sprod;
                     lspf_pkg::OP_MADD: acc_ff <= acc_ff + sprod;
                     default:           acc_ff <= acc_ff - sprod;
                  endcase
                  ph_ff <= PH_IDLE;
               end
            end
            PH_DIV_INIT: begin
               // rounding: add half the divisor before the division
               quo_ff  <= (QW'(abs_a) << lspf_pkg::FRAC) + QW'(abs_b >> 1);
               den_ff  <= abs_b;
               rem_ff  <= '0;
               neg_ff  <= rda_ff[W-1] ^ rdb_ff[W-1];
               dcnt_ff <= DCW'(QW - 1);
               ph_ff   <= PH_DIV;
            end
            PH_DIV: begin
               rem_ff  <= ge ? W'(rem_sh - {1'b0, den_ff}) : rem_sh[W-1:0];
               quo_ff  <= {quo_ff[QW-2:0], ge};
               dcnt_ff <= dcnt_ff - 1'b1;
               if (dcnt_ff == '0) begin
                  ph_ff <= PH_DIV_DONE;
               end
            end
            PH_DIV_DONE: begin
               if (slot_ff == 2'd0) begin
                  coef_ff[0] <= qres;
               end else if (slot_ff == 2'd1) begin
                  coef_ff[1] <= qres;
               end else begin
                  coef_ff[2] <= qres;
               end
               ph_ff <= PH_IDLE;
            end
            default: ph_ff <= PH_IDLE;
         endcase
      end
   end

   assign stat.busy       = (ph_ff != PH_IDLE);
   assign stat.pipe_empty = !v1_ff && !v2_ff;
   assign stat.too_few    = (cnt_ff < CntW'(3));
   assign stat.overflow   = ovf_ff;
   assign stat.acc_zero   = (acc_ff == '0);

   assign coef_const  = coef_ff[0];
   assign coef_linear = coef_ff[1];
   assign coef_square = coef_ff[2];

endmodule

FILE: rtl/lspf_ctrl.sv
// lspf_ctrl: controller of the parabola fit - point intake, drain, solve
// microprogram sequencing and result handshake. Depends on lspf_pkg.
`timescale 1ns / 1ps
module lspf_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pt_accept,
   input  logic                       pt_last,
   input  logic                       rsp_ready,
   input  lspf_pkg::stat_type         stat,
   output lspf_pkg::cmd_type          cmd,
   output logic                       pt_ready,
   output logic                       rsp_valid,
   output lspf_pkg::fit_status_type   fit_status
);
   typedef enum logic [2:0] {
      S_ACCUM, S_DRAIN, S_ISSUE, S_WAIT, S_OUT
   } state_type;

   state_type                      state_ff;
   logic [lspf_pkg::PC_W-1:0]      pc_ff;
   lspf_pkg::fit_status_type       status_ff;
   lspf_pkg::ucode_type            uc;

   assign uc = lspf_pkg::UCODE[pc_ff];

   always_comb begin
      cmd            = '0;
      cmd.op         = uc.op;
      cmd.ra         = uc.ra;
      cmd.rb         = uc.rb;
      cmd.rd         = uc.rd;
      cmd.start      = (state_ff == S_ISSUE);
      cmd.clear_coef = (state_ff == S_DRAIN) && stat.pipe_empty;
      cmd.clear_sums = (state_ff == S_OUT) && rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_ACCUM;
         pc_ff     <= '0;
         status_ff <= lspf_pkg::FIT_OK;
      end else begin
         case (state_ff)
            S_ACCUM: begin
               if (pt_accept && pt_last) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (stat.pipe_empty) begin
                  if (stat.too_few) begin
                     status_ff <= lspf_pkg::FIT_TOO_FEW;
                     state_ff  <= S_OUT;
                  end else begin
                     pc_ff    <= '0;
                     state_ff <= S_ISSUE;
                  end
               end
            end
            S_ISSUE: begin
               case (uc.op)
                  lspf_pkg::OP_CHECK: begin
                     if (stat.acc_zero) begin
                        status_ff <= lspf_pkg::FIT_SINGULAR;
                        state_ff  <= S_OUT;
                     end else begin
                        pc_ff <= pc_ff + 1'b1;
                     end
                  end
                  lspf_pkg::OP_END: begin
                     status_ff <= stat.overflow ? lspf_pkg::FIT_OVERFLOW : lspf_pkg::FIT_OK;
                     state_ff  <= S_OUT;
                  end
                  default: state_ff <= S_WAIT;
               endcase
            end
            S_WAIT: begin
               if (!stat.busy) begin
                  pc_ff    <= pc_ff + 1'b1;
                  state_ff <= S_ISSUE;
               end
            end
            S_OUT: begin
               if (rsp_ready) begin
                  state_ff <= S_ACCUM;
               end
            end
            default: state_ff <= S_ACCUM;
         endcase
      end
   end

   assign pt_ready   = (state_ff == S_ACCUM);
   assign rsp_valid  = (state_ff == S_OUT);
   assign fit_status = status_ff;

endmodule

FILE: rtl/least_squares_parabola_fit_core.sv
// Least-squares parabola fit y = c0 + c1*x + c2*x^2 over a stream of points.
//
// Input channel (req_): one (x, y) point per transfer, req_tlast on the final
// point of a set. Points are taken one per cycle while req_tready is high and
// summed exactly; points beyond MaxPoints are dropped and shown in the status.
// Result channel (rsp_): one transfer per set, three coefficients in signed
// fixed point with 24 fraction bits (saturating) and a status code:
// ok, too few points, singular, or capacity overflowed.
// After the final point the product pipeline drains, then the solve runs a
// microprogram on one shared bit-serial multiplier (36 multiplies, each ending
// once the remaining multiplier is zero) and a restoring divider for each
// coefficient; a whole solve finishes sooner when the sums are small.
// While the solve runs and while the result waits, req_tready stays low.
// The result is held on rsp_tdata until the receiver takes it; a stalled
// receiver just holds the block in that state. Sums clear when it is taken.
// Reset clears all sums, the count and the controller; no clearing pass.
`timescale 1ns / 1ps
module least_squares_parabola_fit_core #(
   parameter int MaxPoints = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // x_value[11:0], y_value[27:12], zero pad
   input  logic         req_tlast,   // last_point
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [199:0] rsp_tdata    // coeff_const, coeff_linear, coeff_square,
                                     // fit_status[193:192], zero pad
);
   lspf_pkg::cmd_type        cmd;
   lspf_pkg::stat_type       stat;
   lspf_pkg::fit_status_type fit_status;
   logic [lspf_pkg::COEF_W-1:0] coeff_const, coeff_linear, coeff_square;
   logic                     pt_accept;

   assign pt_accept = req_tvalid && req_tready;

   lspf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .pt_accept  (pt_accept),
      .pt_last    (req_tlast),
      .rsp_ready  (rsp_tready),
      .stat       (stat),
      .cmd        (cmd),
      .pt_ready   (req_tready),
      .rsp_valid  (rsp_tvalid),
      .fit_status (fit_status)
   );

   lspf_dp #(
      .MaxPoints (MaxPoints)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .pt_valid    (pt_accept),
      .pt_x        (req_tdata[11:0]),
      .pt_y        (req_tdata[27:12]),
      .cmd         (cmd),
      .stat        (stat),
      .coef_const  (coeff_const),
      .coef_linear (coeff_linear),
      .coef_square (coeff_square)
   );

   assign rsp_tdata = {6'd0, fit_status, coeff_square, coeff_linear, coeff_const};

endmodule
